// ===== hw/rtl/mrfc_pkg.sv =====
// package for the modbus rtu receive frame checker
// types, constants and the crc-16 byte update; no dependencies
package mrfc_pkg;

   localparam logic [15:0] CRC_INIT          = 16'hFFFF;
   localparam logic [15:0] CRC_POLY          = 16'hA001;
   localparam logic [7:0]  MIN_FRAME         = 8'd3;
   localparam logic [7:0]  TRAILER_BYTES     = 8'd2;
   localparam logic [7:0]  BUFFER_SIZE_RESET = 8'd64;
   localparam int          RSP_DATA_WIDTH    = 64;
   localparam logic [1:0]  CSR_BUFFER_SIZE   = 2'd0;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_MALFORMED = 2'd2,
      ST_BAD_CRC   = 2'd3
   } status_type;

   typedef enum logic {
      KIND_BYTE  = 1'b0,
      KIND_CLEAR = 1'b1
   } kind_type;

   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [7:0] data_byte;
      logic       last;
   } item_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/mrfc_in_stage.sv =====
// input register of the frame checker
// depends on mrfc_pkg
module mrfc_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // data_byte[7:0]
   input  logic              req_tuser,   // kind
   input  logic              req_tlast,
   input  logic              advance,
   output mrfc_pkg::item_type item
);
   import mrfc_pkg::*;

   item_type item_ff;
   item_type item_in;

   assign req_tready = !item_ff.valid || advance;

   always_comb begin
      item_in = item_ff;
      if (req_tready) begin
         item_in.valid     = req_tvalid;
         item_in.kind      = kind_type'(req_tuser);
         item_in.data_byte = req_tdata;
         item_in.last      = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid     <= 1'b0;
         item_ff.kind      <= KIND_BYTE;
         item_ff.data_byte <= 8'h00;
         item_ff.last      <= 1'b0;
      end else begin
         item_ff <= item_in;
      end
   end

   assign item = item_ff;

endmodule

// ===== hw/rtl/mrfc_frame_check.sv =====
// frame state, crc, verdict, event counters and result register
// depends on mrfc_pkg
module mrfc_frame_check (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [7:0]                           buffer_size,
   input  mrfc_pkg::item_type                   item,
   output logic                                 advance,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [mrfc_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata
);
   import mrfc_pkg::*;

   logic [15:0] crc_ff,  crc_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  held0_ff, held0_in;
   logic [7:0]  held1_ff, held1_in;
   logic [15:0] good_ff, good_in;
   logic [15:0] comm_ff, comm_in;
   logic [15:0] over_ff, over_in;
   logic        out_valid_ff, out_valid_in;
   status_type  status_ff, status_in;
   logic [7:0]  length_ff, length_in;

   logic        fire;

   assign advance = !out_valid_ff || rsp_tready;
   assign fire    = item.valid && advance;

   always_comb begin
      crc_in       = crc_ff;
      count_in     = count_ff;
      held0_in     = held0_ff;
      held1_in     = held1_ff;
      good_in      = good_ff;
      comm_in      = comm_ff;
      over_in      = over_ff;
      status_in    = status_ff;
      length_in    = length_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (fire) begin
         unique case (item.kind)
            KIND_CLEAR: begin
               good_in = 16'h0000;
               comm_in = 16'h0000;
               over_in = 16'h0000;
            end
            KIND_BYTE: begin
               if (count_ff < buffer_size) begin
                  if (count_ff >= TRAILER_BYTES) begin
                     crc_in = crc_feed(crc_ff, held0_ff);
                  end
                  held0_in = held1_ff;
                  held1_in = item.data_byte;
                  count_in = count_ff + 8'd1;
               end
               if (item.last) begin
                  priority if (count_in >= buffer_size) begin
                     status_in = ST_OVERFLOW;
                     over_in   = over_ff + 16'd1;
                  end else if (count_in <= MIN_FRAME) begin
                     status_in = ST_MALFORMED;
                     comm_in   = comm_ff + 16'd1;
                  end else if ({held1_in, held0_in} != crc_in) begin
                     status_in = ST_BAD_CRC;
                     comm_in   = comm_ff + 16'd1;
                  end else begin
                     status_in = ST_OK;
                     good_in   = good_ff + 16'd1;
                  end
                  length_in    = (count_in < buffer_size) ? count_in : buffer_size;
                  out_valid_in = 1'b1;
                  crc_in       = CRC_INIT;
                  count_in     = 8'd0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CRC_INIT;
         count_ff     <= 8'd0;
         good_ff      <= 16'h0000;
         comm_ff      <= 16'h0000;
         over_ff      <= 16'h0000;
         out_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         count_ff     <= count_in;
         good_ff      <= good_in;
         comm_ff      <= comm_in;
         over_ff      <= over_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held0_ff  <= held0_in;
      held1_ff  <= held1_in;
      status_ff <= status_in;
      length_ff <= length_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b000000, over_ff, comm_ff, good_ff, length_ff, status_ff};

endmodule

// ===== hw/rtl/modbus_rtu_rx_frame_check_unit.sv =====
// modbus rtu receive frame checker, top level with the register port
// result: the final byte item is taken into the input register, then its verdict into the result register
// throughput: one item per cycle while rsp_tready does not hold the result; the crc byte update is combinational
// reset: synchronous; buffer_size back to 64, crc to ffff, counts and counters zero
// depends on mrfc_pkg, mrfc_in_stage, mrfc_frame_check
module modbus_rtu_rx_frame_check_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,   // data_byte[7:0]
   input  logic                                 req_tuser,   // kind
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // status[1:0], frame_length[9:2], good_frames[25:10], comm_errors[41:26],
   // overruns[57:42], zero[63:58]
   output logic [mrfc_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [1:0]                           csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   import mrfc_pkg::*;

   logic [7:0] buffer_size_ff, buffer_size_in;
   logic       csr_write;
   item_type   item;
   logic       advance;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      buffer_size_in = buffer_size_ff;
      if (csr_write && (csr_paddr == CSR_BUFFER_SIZE)) begin
         buffer_size_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_size_ff <= BUFFER_SIZE_RESET;
      end else begin
         buffer_size_ff <= buffer_size_in;
      end
   end

   assign csr_prdata = {24'h000000, buffer_size_ff};

   mrfc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .advance    (advance),
      .item       (item)
   );

   mrfc_frame_check u_frame_check (
      .clock       (clock),
      .reset       (reset),
      .buffer_size (buffer_size_ff),
      .item        (item),
      .advance     (advance),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
